// ----- src/lel_pkg.sv -----
package lel_pkg;

    // fixed-point format of every data field
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    // ln(2) in Q30
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // configuration register indexes
    localparam logic CFG_LOSS_KIND = 1'b0;
    localparam logic CFG_DELTA     = 1'b1;

    // loss kinds
    typedef enum logic [2:0] {
        KIND_LOG      = 3'd0,
        KIND_SQUARED  = 3'd1,
        KIND_ABSOLUTE = 3'd2,
        KIND_HUBER    = 3'd3,
        KIND_PSEUDO   = 3'd4
    } loss_kind_t;

    // pipeline stage map
    localparam int ST_IN        = 0;
    localparam int ST_PREP      = 1;
    localparam int ST_MULT      = 2;
    localparam int ST_SEL       = 3;
    localparam int ST_SQ_FIRST  = 4;
    localparam int ST_LOG_LAST  = 33;
    localparam int ST_SQ_LAST   = 36;
    localparam int ST_POST      = 37;
    localparam int ST_DIV_FIRST = 38;
    localparam int ST_DIV_LAST  = 68;
    localparam int NUM_ST       = 69;

    // everything one item carries down the pipeline
    typedef struct packed {
        logic [2:0]         kind;
        logic [30:0]        d;
        logic signed [31:0] y;
        logic signed [31:0] p;
        logic               eneg;
        logic [32:0]        emag;
        logic [3:0]         lb;
        logic [30:0]        x;
        logic [29:0]        frac;
        logic               yneg;
        logic [31:0]        ymag;
        logic               lgneg;
        logic [32:0]        lgmag;
        logic [61:0]        dd;
        logic [65:0]        ee;
        logic [63:0]        de;
        logic [65:0]        nrad;
        logic [34:0]        srem;
        logic [32:0]        root;
        logic [63:0]        drem;
        logic [30:0]        quo;
        logic [20:0]        nl;
        logic               lneg;
        logic               gneg;
        logic [48:0]        lmag;
        logic [33:0]        gmag;
    } pipe_t;

endpackage

// ----- src/elementwise_loss_and_gradient.sv -----
// channel   | direction | tdata (low bit up)            | tuser      | tlast
// s_axis    | in        | target, prediction            | -          | -
// m_axis    | out       | loss_value, gradient          | saturated  | -
// cfg       | in        | 0 loss_kind, 1 delta_threshold (cfg_data) | - | -
//
// 70 register stages: input, prep, multiply, select, 33 square-root steps
// (30 logarithm steps alongside), post multiply, 31 divide steps, output.
// one item per cycle while m_axis does not stall; depth set by the root and divide chains
// a stall on m_axis freezes every stage at once; s_axis_tready follows it
// rst_n clears valid bits and loads loss_kind 1, delta_threshold 1.0
module elementwise_loss_and_gradient
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // target, prediction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // loss_value, gradient
    output logic        m_axis_tuser,   // saturated
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data
);

    lel_pkg::pipe_t pipe_reg  [lel_pkg::NUM_ST];
    lel_pkg::pipe_t pipe_next [lel_pkg::NUM_ST];
    logic [lel_pkg::NUM_ST-1:0] valid_reg;
    logic [lel_pkg::NUM_ST-1:0] valid_next;

    logic [2:0]  kind_reg;
    logic [30:0] delta_reg;
    logic        out_valid_reg;
    logic [31:0] loss_reg, loss_next;
    logic [31:0] grad_reg, grad_next;
    logic        sat_reg, sat_next;
    logic        adv;

    // saturate sign and magnitude to a signed word, flag in the top bit
    function automatic logic [32:0] sat_word(input logic neg, input logic [48:0] mag);
        logic [32:0] r;
        if (!neg)
        begin
            if (mag > 49'h7FFFFFFF)
            begin
                r = {1'b1, 32'h7FFFFFFF};
            end
            else
            begin
                r = {1'b0, mag[31:0]};
            end
        end
        else
        begin
            if (mag > 49'h80000000)
            begin
                r = {1'b1, 32'h80000000};
            end
            else
            begin
                r = {1'b0, 32'(32'd0 - mag[31:0])};
            end
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= lel_pkg::KIND_SQUARED;
            delta_reg <= 31'd65536;
        end
        else if (cfg_we)
        begin
            if (cfg_index == lel_pkg::CFG_LOSS_KIND)
            begin
                kind_reg <= cfg_data[2:0];
            end
            else
            begin
                delta_reg <= cfg_data;
            end
        end
    end

    // whole pipeline moves together
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign valid_next    = {valid_reg[lel_pkg::NUM_ST-2:0], s_axis_tvalid};

    genvar k;
    generate
        for (k = 0; k < lel_pkg::NUM_ST; k++)
        begin : g_st
            if (k == lel_pkg::ST_IN)
            begin : g_in
                always_comb
                begin
                    pipe_next[k]      = '0;
                    pipe_next[k].y    = s_axis_tdata[31:0];
                    pipe_next[k].p    = s_axis_tdata[63:32];
                    pipe_next[k].kind = kind_reg;
                    pipe_next[k].d    = delta_reg;
                end
            end
            else if (k == lel_pkg::ST_PREP)
            begin : g_prep
                lel_prep u_prep (.din(pipe_reg[k-1]), .dout(pipe_next[k]));
            end
            else if (k == lel_pkg::ST_MULT)
            begin : g_mult
                // squares and cross product
                always_comb
                begin
                    pipe_next[k]    = pipe_reg[k-1];
                    pipe_next[k].dd = {31'd0, pipe_reg[k-1].d} * {31'd0, pipe_reg[k-1].d};
                    pipe_next[k].ee = {33'd0, pipe_reg[k-1].emag}
                                    * {33'd0, pipe_reg[k-1].emag};
                    pipe_next[k].de = {33'd0, pipe_reg[k-1].d} * {31'd0, pipe_reg[k-1].emag};
                end
            end
            else if (k == lel_pkg::ST_SEL)
            begin : g_sel
                logic [64:0] lin;
                // radicand and the closed-form kinds
                always_comb
                begin
                    pipe_next[k]      = pipe_reg[k-1];
                    pipe_next[k].nrad = {4'd0, pipe_reg[k-1].dd} + pipe_reg[k-1].ee;
                    pipe_next[k].root = '0;
                    pipe_next[k].srem = '0;
                    pipe_next[k].lneg = 1'b0;
                    pipe_next[k].gneg = pipe_reg[k-1].eneg;
                    pipe_next[k].lmag = '0;
                    pipe_next[k].gmag = '0;
                    lin = {pipe_reg[k-1].de, 1'b0} - {3'd0, pipe_reg[k-1].dd};
                    unique case (pipe_reg[k-1].kind)
                        lel_pkg::KIND_LOG:
                        begin
                            pipe_next[k].lneg = pipe_reg[k-1].yneg;
                            pipe_next[k].gneg = pipe_reg[k-1].lgneg;
                            pipe_next[k].gmag = {1'b0, pipe_reg[k-1].lgmag};
                        end
                        lel_pkg::KIND_SQUARED:
                        begin
                            pipe_next[k].lmag = pipe_reg[k-1].ee[64:16];
                            pipe_next[k].gmag = {pipe_reg[k-1].emag, 1'b0};
                        end
                        lel_pkg::KIND_ABSOLUTE:
                        begin
                            pipe_next[k].lmag = {16'd0, pipe_reg[k-1].emag};
                            pipe_next[k].gmag = (pipe_reg[k-1].emag != '0)
                                              ? 34'(1 << lel_pkg::FRAC_W) : 34'd0;
                        end
                        lel_pkg::KIND_HUBER:
                        begin
                            if (pipe_reg[k-1].emag <= {2'b00, pipe_reg[k-1].d})
                            begin
                                pipe_next[k].lmag = pipe_reg[k-1].ee[65:17];
                                pipe_next[k].gmag = {1'b0, pipe_reg[k-1].emag};
                            end
                            else
                            begin
                                pipe_next[k].lmag = {1'b0, lin[64:17]};
                                pipe_next[k].gmag = {3'd0, pipe_reg[k-1].d};
                            end
                        end
                        lel_pkg::KIND_PSEUDO:
                        begin
                            pipe_next[k].gmag = '0;
                        end
                        default:
                        begin
                            pipe_next[k].gneg = 1'b0;
                        end
                    endcase
                end
            end
            else if (k <= lel_pkg::ST_LOG_LAST)
            begin : g_log_sq
                lel_pkg::pipe_t mid;
                lel_log_step  u_log  (.din(pipe_reg[k-1]), .dout(mid));
                lel_sqrt_step u_sqrt (.din(mid), .dout(pipe_next[k]));
            end
            else if (k <= lel_pkg::ST_SQ_LAST)
            begin : g_sq
                lel_sqrt_step u_sqrt (.din(pipe_reg[k-1]), .dout(pipe_next[k]));
            end
            else if (k == lel_pkg::ST_POST)
            begin : g_post
                logic [34:0] nl2;
                logic [64:0] lnp;
                logic [32:0] sd;
                logic [63:0] pl;
                // -ln from -log2, pseudo-Huber loss, divider load
                always_comb
                begin
                    pipe_next[k] = pipe_reg[k-1];
                    nl2 = {5'(5'd16 - {1'b0, pipe_reg[k-1].lb}), 30'd0}
                        - {5'd0, pipe_reg[k-1].frac};
                    lnp = {30'd0, nl2} * {35'd0, lel_pkg::LN2_Q30};
                    pipe_next[k].nl = lnp[64:44];
                    sd  = pipe_reg[k-1].root - {2'b00, pipe_reg[k-1].d};
                    pl  = {33'd0, pipe_reg[k-1].d} * {31'd0, sd};
                    if (pipe_reg[k-1].kind == lel_pkg::KIND_PSEUDO)
                    begin
                        pipe_next[k].lmag = {1'b0, pl[63:16]};
                    end
                    pipe_next[k].drem = pipe_reg[k-1].de;
                    pipe_next[k].quo  = '0;
                end
            end
            else if (k == lel_pkg::ST_DIV_FIRST)
            begin : g_div0
                lel_pkg::pipe_t mid;
                logic [52:0] lp;
                // log loss |y| * -ln(p)
                always_comb
                begin
                    mid = pipe_reg[k-1];
                    lp  = {21'd0, pipe_reg[k-1].ymag} * {32'd0, pipe_reg[k-1].nl};
                    if (pipe_reg[k-1].kind == lel_pkg::KIND_LOG)
                    begin
                        mid.lmag = {12'd0, lp[52:16]};
                    end
                end
                lel_div_step u_div (.din(mid), .dout(pipe_next[k]));
            end
            else
            begin : g_div
                lel_div_step u_div (.din(pipe_reg[k-1]), .dout(pipe_next[k]));
            end
        end
    endgenerate

    // final kind select and saturation
    always_comb
    begin
        logic [33:0] gm;
        logic [32:0] lw;
        logic [32:0] gw;
        lel_pkg::pipe_t t;
        t  = pipe_reg[lel_pkg::ST_DIV_LAST];
        gm = t.gmag;
        if (t.kind == lel_pkg::KIND_PSEUDO)
        begin
            gm = (t.root == '0) ? 34'd0 : {3'd0, t.quo};
        end
        lw = sat_word(t.lneg, t.lmag);
        gw = sat_word(t.gneg, {15'd0, gm});
        if (t.kind > lel_pkg::KIND_PSEUDO)
        begin
            loss_next = '0;
            grad_next = '0;
            sat_next  = 1'b0;
        end
        else
        begin
            loss_next = lw[31:0];
            grad_next = gw[31:0];
            sat_next  = lw[32] | gw[32];
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg <= pipe_next;
            loss_reg <= loss_next;
            grad_reg <= grad_next;
            sat_reg  <= sat_next;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= valid_reg[lel_pkg::NUM_ST-1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {grad_reg, loss_reg};
    assign m_axis_tuser  = sat_reg;

endmodule

// ----- src/lel_prep.sv -----
module lel_prep
(
    input  lel_pkg::pipe_t din,
    output lel_pkg::pipe_t dout
);

    logic signed [32:0] ediff;
    logic [15:0]        pc;
    logic [33:0]        lgdiff;

    // error sign and magnitude, clamped prediction, log seed
    always_comb
    begin
        dout  = din;
        ediff = {din.p[31], din.p} - {din.y[31], din.y};
        dout.eneg = ediff[32];
        dout.emag = ediff[32] ? 33'(-ediff) : 33'(ediff);

        if (din.p[31] || din.p == 32'sd0)
        begin
            pc = 16'd1;
        end
        else if (din.p >= 32'sd65536)
        begin
            pc = 16'hFFFF;
        end
        else
        begin
            pc = din.p[15:0];
        end

        // leading one of the clamped prediction
        dout.lb = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (pc[i])
            begin
                dout.lb = 4'(i);
            end
        end
        dout.x    = {15'd0, pc} << (5'd30 - {1'b0, dout.lb});
        dout.frac = '0;

        dout.yneg = din.y[31];
        dout.ymag = din.y[31] ? 32'(-din.y) : 32'(din.y);

        // log gradient pc - y
        lgdiff     = {18'd0, pc} - {{2{din.y[31]}}, din.y};
        dout.lgneg = lgdiff[33];
        dout.lgmag = lgdiff[33] ? 33'(-lgdiff) : lgdiff[32:0];
    end

endmodule

// ----- src/lel_log_step.sv -----
module lel_log_step
(
    input  lel_pkg::pipe_t din,
    output lel_pkg::pipe_t dout
);

    logic [61:0] sq;
    logic [31:0] xs;

    // one squaring step of the binary logarithm, one fraction bit out
    always_comb
    begin
        dout = din;
        sq   = {31'd0, din.x} * {31'd0, din.x};
        xs   = sq[61:30];
        if (xs[31])
        begin
            dout.x    = xs[31:1];
            dout.frac = {din.frac[28:0], 1'b1};
        end
        else
        begin
            dout.x    = xs[30:0];
            dout.frac = {din.frac[28:0], 1'b0};
        end
    end

endmodule

// ----- src/lel_sqrt_step.sv -----
module lel_sqrt_step
(
    input  lel_pkg::pipe_t din,
    output lel_pkg::pipe_t dout
);

    logic [36:0] cur;
    logic [36:0] trial;

    // one root bit: bring in two radicand bits, try root*4+1
    always_comb
    begin
        dout      = din;
        cur       = {din.srem, din.nrad[65:64]};
        trial     = {2'b00, din.root, 2'b01};
        dout.nrad = {din.nrad[63:0], 2'b00};
        if (cur >= trial)
        begin
            dout.srem = 35'(cur - trial);
            dout.root = {din.root[31:0], 1'b1};
        end
        else
        begin
            dout.srem = cur[34:0];
            dout.root = {din.root[31:0], 1'b0};
        end
    end

endmodule

// ----- src/lel_div_step.sv -----
module lel_div_step
(
    input  lel_pkg::pipe_t din,
    output lel_pkg::pipe_t dout
);

    logic [63:0] dvs;
    logic [63:0] rem;
    logic        qb;

    // one quotient bit of |e|*d / root, remainder shifts left
    always_comb
    begin
        dout = din;
        dvs  = {1'b0, din.root, 30'd0};
        if (din.drem >= dvs)
        begin
            rem = din.drem - dvs;
            qb  = 1'b1;
        end
        else
        begin
            rem = din.drem;
            qb  = 1'b0;
        end
        dout.drem = {rem[62:0], 1'b0};
        dout.quo  = {din.quo[29:0], qb};
    end

endmodule

// ----- bench/elementwise_loss_and_gradient_tb.sv -----
`timescale 1ns / 1ps

module elementwise_loss_and_gradient_tb;

    localparam int          HALF_PERIOD = 4;
    localparam int          IDLE_LIMIT  = 4000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          TAIL_CYCLES = 100;
    localparam logic [2:0]  KIND_BAD5   = 3'd5;
    localparam logic [2:0]  KIND_BAD6   = 3'd6;
    localparam logic [2:0]  KIND_BAD7   = 3'd7;
    localparam logic [30:0] DELTA_ONE   = 31'd65536;
    localparam logic [30:0] DELTA_MAX   = 31'h7fffffff;
    localparam logic [31:0] POS_MAX     = 32'h7fffffff;
    localparam logic [31:0] NEG_MAX     = 32'h80000000;

    typedef struct {
        logic [31:0] loss;
        logic [31:0] grad;
        logic        sat;
    } loss_result_t;

    typedef struct {
        logic        typed;
        loss_result_t res;
    } override_t;

    typedef struct {
        logic [2:0]  kind;
        logic [30:0] delta;
        logic [31:0] y;
        logic [31:0] p;
        logic        typed;
        logic [31:0] loss;
        logic [31:0] grad;
        logic        sat;
    } vector_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // target, prediction
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // loss_value, gradient
    logic        m_axis_tuser;   // saturated
    logic        cfg_we;
    logic        cfg_index;
    logic [30:0] cfg_data;

    // configuration as the block currently holds it
    logic [2:0]  cur_kind;
    logic [30:0] cur_delta;

    loss_result_t pending_results[$];
    override_t    typed_queue[$];
    int           errors;
    int           checked;
    int           sat_seen;
    int           idle_cycles;
    int           burst_left;
    int           phases_run;
    bit           hold_pending;
    vector_t      vectors[$];

    elementwise_loss_and_gradient dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #HALF_PERIOD clk = ~clk;
    end

    // magnitude clipping to 64 bits
    function automatic logic [63:0] clip64(input logic [127:0] v);
        return (v[127:64] != 0) ? 64'hffffffffffffffff : v[63:0];
    endfunction

    // saturate a sign and magnitude into a 32-bit signed output
    function automatic logic [31:0] to_output(input logic neg, input logic [63:0] mag,
                                              inout logic sat);
        if (!neg)
        begin
            if (mag > 64'h7fffffff)
            begin
                sat = 1'b1;
                return POS_MAX;
            end
            return mag[31:0];
        end
        if (mag > 64'h80000000)
        begin
            sat = 1'b1;
            return NEG_MAX;
        end
        return 32'(-mag);
    endfunction

    // -ln(pc) in Q16 by repeated squaring of the mantissa
    function automatic logic [63:0] neg_log_q16(input logic [63:0] pc);
        int          b;
        logic [63:0] x;
        logic [63:0] frac;
        logic [63:0] nl2;
        b    = 0;
        frac = 0;
        while (b < 62 && (pc >> (b + 1)) != 0)
            b++;
        x = pc << (30 - b);
        for (int i = 1; i <= 30; i++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30))
            begin
                x    = x >> 1;
                frac = frac | (64'd1 << (30 - i));
            end
        end
        nl2 = (64'(16 - b) << 30) - frac;
        return clip64((128'(nl2) * 128'(lel_pkg::LN2_Q30)) >> 44);
    endfunction

    // bitwise floor square root
    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int bit_i = 63; bit_i >= 0; bit_i--)
        begin
            t = r | (64'd1 << bit_i);
            if (128'(t) * 128'(t) <= n)
                r = t;
        end
        return r;
    endfunction

    // loss and gradient for one target/prediction pair
    function automatic loss_result_t loss_grad_model(input logic signed [31:0] y,
                                                     input logic signed [31:0] p);
        loss_result_t       r;
        logic signed [33:0] e;
        logic signed [33:0] gd;
        logic [63:0]        emag;
        logic [63:0]        lmag;
        logic [63:0]        gmag;
        logic [63:0]        d;
        logic [63:0]        pc;
        logic [63:0]        root;
        logic [63:0]        t;
        logic [127:0]       prod;
        logic               lneg;
        logic               gneg;
        logic               sat;
        e    = 34'(p) - 34'(y);
        emag = (e < 0) ? 64'(-e) : 64'(e);
        d    = 64'(cur_delta);
        lmag = 0;
        gmag = 0;
        lneg = 1'b0;
        gneg = (e < 0);
        sat  = 1'b0;
        case (cur_kind)
            lel_pkg::KIND_LOG:
            begin
                if (p <= 0)
                    pc = 1;
                else if (p >= 65536)
                    pc = 65535;
                else
                    pc = 64'(p);
                lneg = (y < 0);
                lmag = clip64((128'((y < 0) ? -64'(y) : 64'(y)) *
                               128'(neg_log_q16(pc))) >> lel_pkg::FRAC_W);
                gd   = 34'($signed({1'b0, pc[31:0]})) - 34'(y);
                gneg = (gd < 0);
                gmag = (gd < 0) ? 64'(-gd) : 64'(gd);
            end
            lel_pkg::KIND_SQUARED:
            begin
                lmag = clip64((128'(emag) * 128'(emag)) >> lel_pkg::FRAC_W);
                gmag = emag * 2;
            end
            lel_pkg::KIND_ABSOLUTE:
            begin
                lmag = emag;
                gmag = (emag != 0) ? 64'd65536 : 64'd0;
            end
            lel_pkg::KIND_HUBER:
            begin
                if (emag <= d)
                begin
                    lmag = clip64((128'(emag) * 128'(emag)) >> (lel_pkg::FRAC_W + 1));
                    gmag = emag;
                end
                else
                begin
                    lmag = clip64((2 * 128'(d) * 128'(emag) - 128'(d) * 128'(d))
                                  >> (lel_pkg::FRAC_W + 1));
                    gmag = d;
                end
            end
            lel_pkg::KIND_PSEUDO:
            begin
                root = floor_sqrt(128'(d) * 128'(d) + 128'(emag) * 128'(emag));
                lmag = clip64((128'(d) * 128'(root - d)) >> lel_pkg::FRAC_W);
                if (root != 0)
                begin
                    prod = 128'(emag) * 128'(d);
                    for (int bit_i = 30; bit_i >= 0; bit_i--)
                    begin
                        t = gmag | (64'd1 << bit_i);
                        if (128'(t) * 128'(root) <= prod)
                            gmag = t;
                    end
                end
            end
            default:
            begin
                r.loss = 0;
                r.grad = 0;
                r.sat  = 1'b0;
                return r;
            end
        endcase
        r.loss = to_output(lneg, lmag, sat);
        r.grad = to_output(gneg, gmag, sat);
        r.sat  = sat;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h (check %0d)", what, got, want, checked);
        errors++;
    endtask

    // input transaction: predict and queue
    always @(posedge clk)
    begin
        override_t ov;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            ov = typed_queue.pop_front();
            if (ov.typed)
                pending_results.push_back(ov.res);
            else
                pending_results.push_back(loss_grad_model(s_axis_tdata[31:0],
                                                          s_axis_tdata[63:32]));
        end
    end

    // output transaction: compare with the oldest expectation
    always @(posedge clk)
    begin
        loss_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected output transaction %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.loss)
                    report("loss_value", m_axis_tdata[31:0], want.loss);
                if (m_axis_tdata[63:32] !== want.grad)
                    report("gradient", m_axis_tdata[63:32], want.grad);
                if (m_axis_tuser !== want.sat)
                    report("saturated", 32'(m_axis_tuser), 32'(want.sat));
                if (m_axis_tuser === 1'b1)
                    sat_seen++;
                checked++;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("elementwise_loss_and_gradient regression: fail");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int run_left;
        int mode;
        run_left = 0;
        mode     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    run_left = $urandom_range(5, 60);
                end
                run_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // offer one pair, in bursts separated by random gaps
    task automatic send_pair(input logic [31:0] y, input logic [31:0] p, input override_t ov);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        typed_queue.push_back(ov);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p, y};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // wait for all results, then write both registers
    task automatic set_config(input logic [2:0] kind, input logic [30:0] delta);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= lel_pkg::CFG_LOSS_KIND;
        cfg_data  <= 31'(kind);
        @(negedge clk);
        cfg_index <= lel_pkg::CFG_DELTA;
        cfg_data  <= delta;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_kind  = kind;
        cur_delta = delta;
        phases_run++;
    endtask

    task automatic add_vec(input logic [2:0] kind, input logic [30:0] delta,
                           input logic [31:0] y, input logic [31:0] p, input logic typed,
                           input logic [31:0] loss, input logic [31:0] grad,
                           input logic sat);
        vector_t v;
        v = '{kind, delta, y, p, typed, loss, grad, sat};
        vectors.push_back(v);
    endtask

    // random operand: full range, small values or extremes
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            2:       return ($urandom_range(0, 1) != 0) ? POS_MAX - $urandom_range(0, 3)
                                                        : NEG_MAX + $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    // main sequence
    initial
    begin
        logic [2:0]  phase_kind[10];
        logic [30:0] phase_delta[10];
        int          phase_len[10];
        override_t   ov;
        logic [31:0] y;
        logic [31:0] p;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = lel_pkg::CFG_LOSS_KIND;
        cfg_data      = '0;
        cur_kind      = lel_pkg::KIND_SQUARED;
        cur_delta     = DELTA_ONE;
        errors        = 0;
        checked       = 0;
        sat_seen      = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        phases_run    = 0;
        hold_pending  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table; reset values first
        add_vec(lel_pkg::KIND_SQUARED, DELTA_ONE, 0, 0, 1, 0, 0, 0);
        add_vec(lel_pkg::KIND_SQUARED, DELTA_ONE, NEG_MAX, POS_MAX, 1, POS_MAX, POS_MAX, 1);
        add_vec(lel_pkg::KIND_SQUARED, DELTA_ONE, POS_MAX, NEG_MAX, 1, POS_MAX, NEG_MAX, 1);
        add_vec(lel_pkg::KIND_SQUARED, DELTA_ONE, 0, 65536, 1, 65536, 131072, 0);
        add_vec(lel_pkg::KIND_ABSOLUTE, DELTA_ONE, 0, 0, 1, 0, 0, 0);
        add_vec(lel_pkg::KIND_ABSOLUTE, DELTA_ONE, 0, 5, 1, 5, 65536, 0);
        add_vec(lel_pkg::KIND_ABSOLUTE, DELTA_ONE, 5, 0, 1, 5, -32'sd65536, 0);
        add_vec(lel_pkg::KIND_ABSOLUTE, DELTA_ONE, NEG_MAX, POS_MAX, 1, POS_MAX, 65536, 1);
        add_vec(lel_pkg::KIND_LOG, DELTA_ONE, 0, 0, 1, 0, 1, 0);
        add_vec(lel_pkg::KIND_LOG, DELTA_ONE, NEG_MAX, 1, 1, NEG_MAX, POS_MAX, 1);
        add_vec(lel_pkg::KIND_LOG, DELTA_ONE, 65536, NEG_MAX, 0, 0, 0, 0);
        add_vec(lel_pkg::KIND_LOG, DELTA_ONE, 65536, POS_MAX, 0, 0, 0, 0);
        add_vec(lel_pkg::KIND_LOG, DELTA_ONE, 65536, 32768, 0, 0, 0, 0);
        add_vec(lel_pkg::KIND_HUBER, DELTA_ONE, 0, 65536, 0, 0, 0, 0);
        add_vec(lel_pkg::KIND_HUBER, DELTA_ONE, 0, 3 * 65536, 0, 0, 0, 0);
        add_vec(lel_pkg::KIND_HUBER, DELTA_ONE, 0, -32'sd196608, 0, 0, 0, 0);
        add_vec(lel_pkg::KIND_HUBER, 31'd0, 0, 100, 1, 0, 0, 0);
        add_vec(lel_pkg::KIND_HUBER, 31'd0, 0, 0, 1, 0, 0, 0);
        add_vec(lel_pkg::KIND_PSEUDO, 31'd0, 7, 7, 1, 0, 0, 0);
        add_vec(lel_pkg::KIND_PSEUDO, 31'd0, 0, 100, 0, 0, 0, 0);
        add_vec(lel_pkg::KIND_PSEUDO, DELTA_MAX, NEG_MAX, POS_MAX, 0, 0, 0, 0);
        add_vec(lel_pkg::KIND_PSEUDO, DELTA_MAX, 0, 0, 0, 0, 0, 0);
        add_vec(KIND_BAD5, DELTA_ONE, 1000, 3, 1, 0, 0, 0);
        add_vec(KIND_BAD6, DELTA_ONE, NEG_MAX, POS_MAX, 1, 0, 0, 0);
        add_vec(KIND_BAD7, DELTA_ONE, POS_MAX, NEG_MAX, 1, 0, 0, 0);

        foreach (vectors[i])
        begin
            if (vectors[i].kind != cur_kind || vectors[i].delta != cur_delta)
                set_config(vectors[i].kind, vectors[i].delta);
            ov.typed    = vectors[i].typed;
            ov.res.loss = vectors[i].loss;
            ov.res.grad = vectors[i].grad;
            ov.res.sat  = vectors[i].sat;
            send_pair(vectors[i].y, vectors[i].p, ov);
        end

        // random phases over kinds and delta settings
        phase_kind  = '{lel_pkg::KIND_SQUARED, lel_pkg::KIND_LOG, lel_pkg::KIND_ABSOLUTE,
                        lel_pkg::KIND_HUBER, lel_pkg::KIND_HUBER, lel_pkg::KIND_PSEUDO,
                        lel_pkg::KIND_PSEUDO, lel_pkg::KIND_HUBER, lel_pkg::KIND_PSEUDO,
                        KIND_BAD7};
        phase_delta = '{DELTA_ONE, DELTA_ONE, DELTA_ONE, 31'd1, DELTA_MAX,
                        31'd1, DELTA_MAX, 31'($urandom_range(1, 8 * 65536)),
                        31'($urandom_range(1, 8 * 65536)), DELTA_ONE};
        phase_len   = '{200, 220, 180, 180, 180, 180, 180, 200, 200, 100};
        ov.typed = 1'b0;
        for (int ph = 0; ph < 10; ph++)
        begin
            set_config(phase_kind[ph], phase_delta[ph]);
            if (ph == 3)
                hold_pending = 1'b1;
            for (int n = 0; n < phase_len[ph]; n++)
            begin
                y = rand_operand();
                if (phase_kind[ph] == lel_pkg::KIND_LOG && $urandom_range(0, 3) != 0)
                    p = 32'($signed($urandom_range(0, 70000)) - 2000);
                else if ($urandom_range(0, 2) == 0)
                    p = y + 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
                else
                    p = rand_operand();
                send_pair(y, p, ov);
            end
        end

        // drain, then a tail for anything late
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        $display("checked %0d results over %0d register settings, %0d saturated",
                 checked, phases_run, sat_seen);
        $display("all five loss kinds, unknown kinds, zero and extreme deltas covered");
        if (errors == 0)
            $display("elementwise_loss_and_gradient regression: pass");
        else
            $display("elementwise_loss_and_gradient regression: fail");
        $finish;
    end

endmodule

// ----- elementwise_loss_and_gradient.f -----
src/lel_pkg.sv
src/lel_prep.sv
src/lel_log_step.sv
src/lel_sqrt_step.sv
src/lel_div_step.sv
src/elementwise_loss_and_gradient.sv
bench/elementwise_loss_and_gradient_tb.sv
